/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the frame engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define STX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define STX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define STX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/stx_pkg.sv */
// ----------------------------------------------------------------------------
// stx_pkg
// shared types and codes of the stx command frame engine
// ----------------------------------------------------------------------------
package stx_pkg;

  localparam int MaxRun = 4;
  localparam int RunCountWidth = 3;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_RECEIVE = 2'd2,
    CMD_ABORT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic       status;
    logic [7:0] device_result;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [RunCountWidth-1:0] count;
    result_t [MaxRun-1:0]     slot;
  } run_t;

  function automatic result_t make_result(kind_t k, logic [7:0] b, logic s,
                                          logic [7:0] d);
    result_t r;
    r.kind          = k;
    r.byte_value    = b;
    r.status        = s;
    r.device_result = d;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/stx_frame_core.sv */
// ----------------------------------------------------------------------------
// stx_frame_core
// frame sequencer: holds link state and turns one item into its result run
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stx_frame_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              fire,
  input  logic [1:0]        cmd,
  input  logic [7:0]        command_code,
  input  logic [7:0]        payload_length,
  input  logic [7:0]        data_byte,
  output stx_pkg::run_t     run
);

  localparam logic [7:0] MinReplyLen   = 8'd2;
  localparam logic [7:0] MaxReplyLen   = 8'd127;
  localparam logic [7:0] StartReset    = 8'd2;
  localparam logic [7:0] AckReset      = 8'd6;
  localparam logic       RegStart      = 1'b0;
  localparam logic       RegAck        = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PAYLOAD, PH_ACK, PH_STX, PH_LEN,
    PH_CMD, PH_RESULT, PH_DATA, PH_CRC
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] start_code, acknowledge_code;
  logic [7:0] expected_command, expected_command_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] bytes_remaining, bytes_remaining_next;
  logic [7:0] held_result, held_result_next;

  stx_pkg::run_t run_raw;

  always_comb begin
    logic [7:0] lenb;
    logic [7:0] x;
    logic [7:0] rem;
    phase_next            = phase;
    expected_command_next = expected_command;
    running_xor_next      = running_xor;
    bytes_remaining_next  = bytes_remaining;
    held_result_next      = held_result;
    run_raw               = '0;
    lenb                  = payload_length + 8'd1;
    x                     = running_xor ^ data_byte;
    rem                   = bytes_remaining - 8'd1;

    case (stx_pkg::cmd_t'(cmd))
      stx_pkg::CMD_BEGIN: begin
        if (phase == PH_IDLE) begin
          expected_command_next = command_code;
          running_xor_next      = lenb ^ command_code;
          bytes_remaining_next  = payload_length;
          run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_TX, start_code,
                                                 stx_pkg::STATUS_OK, 8'd0);
          run_raw.slot[1] = stx_pkg::make_result(stx_pkg::KIND_TX, lenb,
                                                 stx_pkg::STATUS_OK, 8'd0);
          run_raw.slot[2] = stx_pkg::make_result(stx_pkg::KIND_TX, command_code,
                                                 stx_pkg::STATUS_OK, 8'd0);
          if (payload_length == 8'd0) begin
            run_raw.slot[3] = stx_pkg::make_result(stx_pkg::KIND_TX,
                                                   lenb ^ command_code,
                                                   stx_pkg::STATUS_OK, 8'd0);
            run_raw.count = 3'd4;
            phase_next    = PH_ACK;
          end else begin
            run_raw.count = 3'd3;
            phase_next    = PH_PAYLOAD;
          end
        end
      end
      stx_pkg::CMD_PAYLOAD: begin
        if (phase == PH_PAYLOAD) begin
          running_xor_next     = x;
          bytes_remaining_next = rem;
          run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_TX, data_byte,
                                                 stx_pkg::STATUS_OK, 8'd0);
          if (rem == 8'd0) begin
            // checksum follows the last payload byte
            run_raw.slot[1] = stx_pkg::make_result(stx_pkg::KIND_TX, x,
                                                   stx_pkg::STATUS_OK, 8'd0);
            run_raw.count = 3'd2;
            phase_next    = PH_ACK;
          end else begin
            run_raw.count = 3'd1;
          end
        end
      end
      stx_pkg::CMD_RECEIVE: begin
        case (phase)
          PH_ACK: begin
            if (data_byte == acknowledge_code) begin
              phase_next = PH_STX;
            end else begin
              run_raw.count = 3'd1;
            end
          end
          PH_STX: begin
            if (data_byte == start_code) begin
              phase_next = PH_LEN;
            end else begin
              run_raw.count = 3'd1;
            end
          end
          PH_LEN: begin
            if (data_byte >= MinReplyLen && data_byte <= MaxReplyLen) begin
              running_xor_next     = data_byte;
              bytes_remaining_next = data_byte - MinReplyLen;
              phase_next           = PH_CMD;
            end else begin
              run_raw.count = 3'd1;
            end
          end
          PH_CMD: begin
            if (data_byte == expected_command) begin
              running_xor_next = x;
              phase_next       = PH_RESULT;
            end else begin
              run_raw.count = 3'd1;
            end
          end
          PH_RESULT: begin
            running_xor_next = x;
            held_result_next = data_byte;
            phase_next       = (bytes_remaining == 8'd0) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            running_xor_next     = x;
            bytes_remaining_next = rem;
            run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_DATA, data_byte,
                                                   stx_pkg::STATUS_OK, 8'd0);
            run_raw.count = 3'd1;
            if (rem == 8'd0) begin
              phase_next = PH_CRC;
            end
          end
          PH_CRC: begin
            run_raw.count = 3'd1;
            if (data_byte == running_xor) begin
              phase_next = PH_IDLE;
              run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_STATUS, 8'd0,
                                                     stx_pkg::STATUS_OK,
                                                     held_result);
            end
          end
          default: begin
          end
        endcase
        // every single-result mismatch above is a failure status
        if (run_raw.count == 3'd1 && phase != PH_DATA &&
            !(phase == PH_CRC && data_byte == running_xor)) begin
          phase_next      = PH_IDLE;
          run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_STATUS, 8'd0,
                                                 stx_pkg::STATUS_FAIL, 8'd0);
        end
      end
      stx_pkg::CMD_ABORT: begin
        if (phase != PH_IDLE) begin
          phase_next      = PH_IDLE;
          run_raw.slot[0] = stx_pkg::make_result(stx_pkg::KIND_STATUS, 8'd0,
                                                 stx_pkg::STATUS_FAIL, 8'd0);
          run_raw.count   = 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // mark the last result of the run
  always_comb begin
    run = run_raw;
    for (int i = 0; i < stx_pkg::MaxRun; i++) begin
      run.slot[i].last = (run_raw.count == stx_pkg::RunCountWidth'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      expected_command <= 8'd0;
      running_xor      <= 8'd0;
      bytes_remaining  <= 8'd0;
      held_result      <= 8'd0;
      start_code       <= StartReset;
      acknowledge_code <= AckReset;
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegStart) begin
          start_code <= cfg_data;
        end
        if (cfg_index == RegAck) begin
          acknowledge_code <= cfg_data;
        end
      end
      if (fire) begin
        phase            <= phase_next;
        expected_command <= expected_command_next;
        running_xor      <= running_xor_next;
        bytes_remaining  <= bytes_remaining_next;
        held_result      <= held_result_next;
      end
    end
  end

  `STX_ASSERT_NEXT(a_abort_idles,
    fire && cmd == stx_pkg::CMD_ABORT, phase == PH_IDLE,
    "abort did not return the sequencer to idle")
  `STX_ASSERT_SAME(a_status_ends_wait,
    fire && run.count != 3'd0 && run.slot[0].kind == stx_pkg::KIND_STATUS,
    phase_next == PH_IDLE,
    "final status issued while the transaction stays open")

endmodule

/* hw/rtl/stx_result_queue.sv */
// ----------------------------------------------------------------------------
// stx_result_queue
// holds one run of results and drains it through the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stx_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stx_pkg::run_t     run_in,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output stx_pkg::result_t  out_res
);

  logic [stx_pkg::RunCountWidth-1:0] run_count;
  stx_pkg::result_t [stx_pkg::MaxRun-1:0] slot;
  logic out_free;
  logic out_load;

  assign out_free = !out_valid || out_ready;
  assign out_load = (run_count != '0) && out_free;
  // a new run may enter once the current one is down to its last entry
  assign in_ready = (run_count == '0) || (run_count == 3'd1 && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push) begin
        run_count <= run_in.count;
      end else if (out_load) begin
        run_count <= run_count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= slot[0];
    end
    if (push) begin
      slot <= run_in.slot;
    end else if (out_load) begin
      for (int i = 0; i < stx_pkg::MaxRun - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  `STX_ASSERT_ALWAYS(a_count_range, run_count <= 3'(stx_pkg::MaxRun),
    "run buffer holds more results than one item can cause")
  `STX_ASSERT_SAME(a_push_when_drained, push,
    run_count == '0 || (run_count == 3'd1 && out_load),
    "new run overwrote results not yet passed on")
  `STX_ASSERT_NEXT(a_pending_shown, run_count != '0 && !out_valid, out_valid,
    "pending result not moved to the output register")

endmodule

/* hw/rtl/stx_xor_command_frame_engine.sv */
// ----------------------------------------------------------------------------
// stx_xor_command_frame_engine
// stx / length / command / xor checksum framing and reply checking
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    cmd, command_code, payload_length, data_byte
//  out      out_valid/out_ready  kind, byte_value, status, device_result,
//                                last_of_run
//  cfg      cfg_we               cfg_index, cfg_data
//
// an item is decoded in the cycle it is accepted; its run of 0 to 4 results
// leaves through the output register one per cycle while out_ready is high;
// a begin gives 3 or 4 results. the next item is taken while the last result
// of the previous run moves out. out_ready low holds the output register and
// the run buffer, which drops in_ready. synchronous reset returns the
// sequencer to idle and the start and acknowledge codes to 2 and 6.
module stx_xor_command_frame_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] command_code,
  input  logic [7:0] payload_length,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] byte_value,
  output logic       status,
  output logic [7:0] device_result,
  output logic       last_of_run
);

  logic             fire;
  stx_pkg::run_t    run;
  stx_pkg::result_t out_res;

  assign fire = in_valid && in_ready;

  stx_frame_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fire           (fire),
    .cmd            (cmd),
    .command_code   (command_code),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .run            (run)
  );

  stx_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .run_in    (run),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind          = out_res.kind;
  assign byte_value    = out_res.byte_value;
  assign status        = out_res.status;
  assign device_result = out_res.device_result;
  assign last_of_run   = out_res.last;

endmodule
